/* sv/wam_pkg.sv */
// Shared widths, limits and types for the weighted average audio mixer.
package wam_pkg;

    localparam int TRACKS_DEF = 8;
    localparam int NUM_VOLS   = 8;
    localparam int SAMPLE_W   = 16;
    localparam int VOL_W      = 16;
    localparam int PROD_W     = VOL_W + SAMPLE_W + 1;
    localparam int QUO_W      = 17;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int VIDX_W     = 3;

    localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(32767);
    localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(32768);
    localparam logic [SAMPLE_W-1:0] MIX_MAX = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] MIX_MIN = 16'h8000;
    localparam logic [VOL_W-1:0] VOL_RESET = 16'h0100;

    typedef struct packed {
        logic neg;
        logic zero;
    } wam_flags_t;

endpackage

/* sv/wam_acc_cell.sv */
// Accumulate cell: adds one track's weighted sample and weight to the running sums when its mask bit is set.
module wam_acc_cell #(
    parameter int TRACKS = wam_pkg::TRACKS_DEF,
    parameter int IDX    = 0,
    parameter int SUM_W  = 36,
    parameter int VSUM_W = 20
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic [wam_pkg::VOL_W-1:0]                   vol,
    input  logic                                        in_valid,
    input  logic [TRACKS-1:0]                           in_mask,
    input  logic [TRACKS-1:0][wam_pkg::SAMPLE_W-1:0]    in_samples,
    input  logic signed [SUM_W-1:0]                     in_sum,
    input  logic [VSUM_W-1:0]                           in_vsum,
    output logic                                        out_valid,
    output logic [TRACKS-1:0]                           out_mask,
    output logic [TRACKS-1:0][wam_pkg::SAMPLE_W-1:0]    out_samples,
    output logic signed [SUM_W-1:0]                     out_sum,
    output logic [VSUM_W-1:0]                           out_vsum
);

    logic signed [wam_pkg::PROD_W-1:0]               prod;
    logic signed [SUM_W-1:0]                         sum_next;
    logic [VSUM_W-1:0]                               vsum_next;
    logic                                            valid_reg;
    logic [TRACKS-1:0]                               mask_reg;
    logic [TRACKS-1:0][wam_pkg::SAMPLE_W-1:0]        samples_reg;
    logic signed [SUM_W-1:0]                         sum_reg;
    logic [VSUM_W-1:0]                               vsum_reg;

    assign prod = $signed({1'b0, vol}) * $signed(in_samples[IDX]);

    always_comb
    begin
        if (in_mask[IDX])
        begin
            sum_next  = in_sum + SUM_W'(prod);
            vsum_next = in_vsum + VSUM_W'(vol);
        end
        else
        begin
            sum_next  = in_sum;
            vsum_next = in_vsum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mask_reg    <= in_mask;
            samples_reg <= in_samples;
            sum_reg     <= sum_next;
            vsum_reg    <= vsum_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_mask    = mask_reg;
    assign out_samples = samples_reg;
    assign out_sum     = sum_reg;
    assign out_vsum    = vsum_reg;

endmodule

/* sv/wam_div_cell.sv */
// Divider cell: settles one quotient bit of the restoring division.
module wam_div_cell #(
    parameter int CMP_W  = 37,
    parameter int VSUM_W = 20,
    parameter int QW     = wam_pkg::QUO_W,
    parameter int SHIFT  = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [CMP_W-1:0]        in_rem,
    input  logic [VSUM_W-1:0]       in_div,
    input  logic [QW-1:0]           in_quo,
    input  wam_pkg::wam_flags_t     in_flags,
    output logic                    out_valid,
    output logic [CMP_W-1:0]        out_rem,
    output logic [VSUM_W-1:0]       out_div,
    output logic [QW-1:0]           out_quo,
    output wam_pkg::wam_flags_t     out_flags
);

    logic [CMP_W-1:0]       trial;
    logic                   take;
    logic [CMP_W-1:0]       rem_next;
    logic [QW-1:0]          quo_next;
    logic                   valid_reg;
    logic [CMP_W-1:0]       rem_reg;
    logic [VSUM_W-1:0]      div_reg;
    logic [QW-1:0]          quo_reg;
    wam_pkg::wam_flags_t    flags_reg;

    assign trial = CMP_W'(in_div) << SHIFT;
    assign take  = (in_rem >= trial);

    always_comb
    begin
        rem_next = in_rem;
        quo_next = in_quo;
        if (take)
        begin
            rem_next = in_rem - trial;
            quo_next = in_quo | (QW'(1) << SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= rem_next;
            div_reg   <= in_div;
            quo_reg   <= quo_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_quo   = quo_reg;
    assign out_flags = flags_reg;

endmodule

/* sv/weighted_average_audio_mixer.sv */
// Weighted average audio mixer: one sample instant per beat in, one mixed sample per beat out.
// The block takes one sample instant in every cycle while in_ready is high and returns one mixed
// sample for each, in order. A beat passes a chain of TRACKS multiply-accumulate cells (one
// track each), a sign/magnitude stage, a chain of 17 restoring divider cells (one quotient bit
// each) and the output register. A two-entry output buffer absorbs stalls; in_ready drops only
// while both entries hold results that have not been taken. The quotient is truncated toward
// zero; a zero weight sum gives zero with no_weight set. Volumes are written through the APB
// port at byte address 4*k and should change only while no beat is in flight.
module weighted_average_audio_mixer #(
    parameter int TRACKS = wam_pkg::TRACKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wam_pkg::ADDR_W-1:0]          paddr,
    input  logic [wam_pkg::DATA_W-1:0]          pwdata,
    output logic [wam_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [wam_pkg::SAMPLE_W-1:0] sample_0,
    input  logic signed [wam_pkg::SAMPLE_W-1:0] sample_1,
    input  logic signed [wam_pkg::SAMPLE_W-1:0] sample_2,
    input  logic signed [wam_pkg::SAMPLE_W-1:0] sample_3,
    input  logic signed [wam_pkg::SAMPLE_W-1:0] sample_4,
    input  logic signed [wam_pkg::SAMPLE_W-1:0] sample_5,
    input  logic signed [wam_pkg::SAMPLE_W-1:0] sample_6,
    input  logic signed [wam_pkg::SAMPLE_W-1:0] sample_7,
    input  logic [7:0]                          active_mask,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [wam_pkg::SAMPLE_W-1:0] mixed_sample,
    output logic                                no_weight
);

    localparam int SW     = wam_pkg::SAMPLE_W;
    localparam int QW     = wam_pkg::QUO_W;
    localparam int SUM_W  = wam_pkg::PROD_W + $clog2(TRACKS);
    localparam int VSUM_W = wam_pkg::VOL_W + $clog2(TRACKS + 1);
    localparam int CMP_W  = VSUM_W + QW;

    // Configuration registers
    logic [wam_pkg::NUM_VOLS-1:0][wam_pkg::VOL_W-1:0]  vol_reg;
    logic [wam_pkg::VIDX_W-1:0]                         reg_idx;
    logic                                               cfg_write;

    assign reg_idx   = paddr[wam_pkg::VIDX_W+1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = wam_pkg::DATA_W'(vol_reg[reg_idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < wam_pkg::NUM_VOLS; k++)
            begin
                vol_reg[k] <= wam_pkg::VOL_RESET;
            end
        end
        else if (cfg_write)
        begin
            vol_reg[reg_idx] <= pwdata[wam_pkg::VOL_W-1:0];
        end
    end

    // Pipeline advances while the output buffer has room
    logic skid_full_reg;
    logic en;

    assign en       = !skid_full_reg;
    assign in_ready = en;

    // Accumulate chain
    logic [7:0][SW-1:0]                 all_samples;
    logic                               acc_valid   [0:TRACKS];
    logic [TRACKS-1:0]                  acc_mask    [0:TRACKS];
    logic [TRACKS-1:0][SW-1:0]          acc_samples [0:TRACKS];
    logic signed [SUM_W-1:0]            acc_sum     [0:TRACKS];
    logic [VSUM_W-1:0]                  acc_vsum    [0:TRACKS];

    assign all_samples = {sample_7, sample_6, sample_5, sample_4,
                          sample_3, sample_2, sample_1, sample_0};

    assign acc_valid[0]   = in_valid;
    assign acc_mask[0]    = active_mask[TRACKS-1:0];
    assign acc_samples[0] = all_samples[TRACKS-1:0];
    assign acc_sum[0]     = '0;
    assign acc_vsum[0]    = '0;

    for (genvar k = 0; k < TRACKS; k++)
    begin : g_acc
        wam_acc_cell #(
            .TRACKS (TRACKS),
            .IDX    (k),
            .SUM_W  (SUM_W),
            .VSUM_W (VSUM_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (en),
            .vol         (vol_reg[k]),
            .in_valid    (acc_valid[k]),
            .in_mask     (acc_mask[k]),
            .in_samples  (acc_samples[k]),
            .in_sum      (acc_sum[k]),
            .in_vsum     (acc_vsum[k]),
            .out_valid   (acc_valid[k+1]),
            .out_mask    (acc_mask[k+1]),
            .out_samples (acc_samples[k+1]),
            .out_sum     (acc_sum[k+1]),
            .out_vsum    (acc_vsum[k+1])
        );
    end

    // Sign/magnitude stage
    logic                   prep_valid_reg;
    logic [CMP_W-1:0]       prep_rem_reg;
    logic [VSUM_W-1:0]      prep_div_reg;
    wam_pkg::wam_flags_t    prep_flags_reg;
    logic [SUM_W-1:0]       sum_mag;
    wam_pkg::wam_flags_t    prep_flags_next;

    assign sum_mag = acc_sum[TRACKS][SUM_W-1] ? SUM_W'(-acc_sum[TRACKS])
                                              : SUM_W'(acc_sum[TRACKS]);
    assign prep_flags_next.neg  = acc_sum[TRACKS][SUM_W-1];
    assign prep_flags_next.zero = (acc_vsum[TRACKS] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= acc_valid[TRACKS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_rem_reg   <= CMP_W'(sum_mag);
            prep_div_reg   <= acc_vsum[TRACKS];
            prep_flags_reg <= prep_flags_next;
        end
    end

    // Divider chain, most significant quotient bit first
    logic                   div_valid [0:QW];
    logic [CMP_W-1:0]       div_rem   [0:QW];
    logic [VSUM_W-1:0]      div_div   [0:QW];
    logic [QW-1:0]          div_quo   [0:QW];
    wam_pkg::wam_flags_t    div_flags [0:QW];

    assign div_valid[0] = prep_valid_reg;
    assign div_rem[0]   = prep_rem_reg;
    assign div_div[0]   = prep_div_reg;
    assign div_quo[0]   = '0;
    assign div_flags[0] = prep_flags_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        wam_div_cell #(
            .CMP_W  (CMP_W),
            .VSUM_W (VSUM_W),
            .QW     (QW),
            .SHIFT  (QW - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[j]),
            .in_rem    (div_rem[j]),
            .in_div    (div_div[j]),
            .in_quo    (div_quo[j]),
            .in_flags  (div_flags[j]),
            .out_valid (div_valid[j+1]),
            .out_rem   (div_rem[j+1]),
            .out_div   (div_div[j+1]),
            .out_quo   (div_quo[j+1]),
            .out_flags (div_flags[j+1])
        );
    end

    // Sign, saturate and flag the quotient
    logic [QW-1:0]          qmag;
    wam_pkg::wam_flags_t    qflags;
    logic [SW-1:0]          res_sample;
    logic                   res_flag;

    assign qmag   = div_quo[QW];
    assign qflags = div_flags[QW];

    always_comb
    begin
        res_flag = qflags.zero;
        if (qflags.zero)
        begin
            res_sample = '0;
        end
        else if (qflags.neg)
        begin
            if (qmag > wam_pkg::NEG_LIM)
            begin
                res_sample = wam_pkg::MIX_MIN;
            end
            else
            begin
                res_sample = SW'(-qmag);
            end
        end
        else if (qmag > wam_pkg::POS_LIM)
        begin
            res_sample = wam_pkg::MIX_MAX;
        end
        else
        begin
            res_sample = qmag[SW-1:0];
        end
    end

    // Output register with one skid entry
    logic               out_valid_reg;
    logic [SW-1:0]      out_sample_reg;
    logic               out_flag_reg;
    logic [SW-1:0]      skid_sample_reg;
    logic               skid_flag_reg;
    logic               load_main;
    logic               load_skid;
    logic               drain_skid;

    assign drain_skid = skid_full_reg && out_ready;
    assign load_main  = !skid_full_reg && div_valid[QW] && (!out_valid_reg || out_ready);
    assign load_skid  = !skid_full_reg && div_valid[QW] && out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (drain_skid)
            begin
                skid_full_reg <= 1'b0;
            end
            else if (load_skid)
            begin
                skid_full_reg <= 1'b1;
            end

            if (load_main || drain_skid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain_skid)
        begin
            out_sample_reg <= skid_sample_reg;
            out_flag_reg   <= skid_flag_reg;
        end
        else if (load_main)
        begin
            out_sample_reg <= res_sample;
            out_flag_reg   <= res_flag;
        end

        if (load_skid)
        begin
            skid_sample_reg <= res_sample;
            skid_flag_reg   <= res_flag;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mixed_sample = out_sample_reg;
    assign no_weight    = out_flag_reg;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the weighted average audio mixer.
`timescale 1ns / 1ps

module tb;

    localparam int TRACK_CNT  = 8;
    localparam int VOL_BASE   = 0;
    localparam int REG_STRIDE = 4;
    localparam int HOLD_LEN   = 400;
    localparam int TAIL_LEN   = 40;

    typedef logic signed [wam_pkg::SAMPLE_W-1:0] sample_t;
    typedef sample_t track_samples_t [TRACK_CNT];
    typedef logic [wam_pkg::VOL_W-1:0] vol_t;
    typedef logic [wam_pkg::ADDR_W-1:0] addr_t;

    typedef struct {
        sample_t mixed_sample;
        logic    no_weight;
    } mix_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_COMB
    } rx_mode_t;

    class mix_scoreboard;
        vol_t             vols [TRACK_CNT];
        mix_t             pending_mixes [$];
        int               errors;

        function new();
            foreach (vols[k])
                vols[k] = wam_pkg::VOL_RESET;
            errors = 0;
        endfunction

        function void set_volume(int k, logic [wam_pkg::DATA_W-1:0] data);
            vols[k] = data[wam_pkg::VOL_W-1:0];
        endfunction

        function int pending();
            return pending_mixes.size();
        endfunction

        // weighted mean over the active tracks, truncated toward zero
        function mix_t predict_mix(track_samples_t s, logic [7:0] m);
            longint wsum;
            longint vsum;
            longint quo;
            mix_t   r;
            wsum = 0;
            vsum = 0;
            for (int k = 0; k < TRACK_CNT; k++)
            begin
                if (m[k])
                begin
                    wsum += longint'(vols[k]) * longint'(s[k]);
                    vsum += longint'(vols[k]);
                end
            end
            if (vsum == 0)
            begin
                r.mixed_sample = '0;
                r.no_weight    = 1'b1;
            end
            else
            begin
                quo = wsum / vsum;
                if (quo > 32767)
                    quo = 32767;
                if (quo < -32768)
                    quo = -32768;
                r.mixed_sample = quo[wam_pkg::SAMPLE_W-1:0];
                r.no_weight    = 1'b0;
            end
            return r;
        endfunction

        function void note_instant(track_samples_t s, logic [7:0] m);
            pending_mixes.push_back(predict_mix(s, m));
        endfunction

        function void check_mix(sample_t mix, logic nw);
            mix_t want;
            if (pending_mixes.size() == 0)
            begin
                $error("mixed_sample: result %0d arrived with nothing expected", mix);
                errors++;
                return;
            end
            want = pending_mixes.pop_front();
            if (mix !== want.mixed_sample)
            begin
                $error("mixed_sample: expected %0d, actual %0d", want.mixed_sample, mix);
                errors++;
            end
            if (nw !== want.no_weight)
            begin
                $error("no_weight: expected %0b, actual %0b", want.no_weight, nw);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    addr_t                         paddr;
    logic [wam_pkg::DATA_W-1:0]    pwdata;
    logic [wam_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    sample_t                       smp_drv [TRACK_CNT];
    logic [7:0]                    mask_drv;
    logic                          out_valid;
    logic                          out_ready;
    sample_t                       mixed_sample;
    logic                          no_weight;

    mix_scoreboard sb;
    int            burst_left;
    int            rx_cycle;
    rx_mode_t      rx_mode;
    logic          rx_take;
    logic          rx_hold;

    weighted_average_audio_mixer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_0     (smp_drv[0]),
        .sample_1     (smp_drv[1]),
        .sample_2     (smp_drv[2]),
        .sample_3     (smp_drv[3]),
        .sample_4     (smp_drv[4]),
        .sample_5     (smp_drv[5]),
        .sample_6     (smp_drv[6]),
        .sample_7     (smp_drv[7]),
        .active_mask  (mask_drv),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mixed_sample (mixed_sample),
        .no_weight    (no_weight)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: check every beat taken, stall on one of four patterns chosen at random, or while held
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_mix(mixed_sample, no_weight);
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   rx_take = 1'b1;
            RX_COIN:   rx_take = 1'($urandom_range(0, 1));
            RX_SPARSE: rx_take = ($urandom_range(0, 3) == 0);
            default:   rx_take = (rx_cycle % 5 != 2);
        endcase
        out_ready <= rx_take && !rx_hold;
    end

    task automatic hold_receiver(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    task automatic write_volume(input int k, input vol_t v);
        logic [wam_pkg::DATA_W-1:0] data;
        data = {16'($urandom), v};
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr_t'(VOL_BASE + REG_STRIDE * k);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_volume(k, data);
    endtask

    task automatic drain_mixes();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // steady: no sender gaps; otherwise bursts of random length with random gaps
    task automatic send_instant(input track_samples_t s, input logic [7:0] m,
                                input bit steady);
        if (!steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int k = 0; k < TRACK_CNT; k++)
            smp_drv[k] <= s[k];
        mask_drv <= m;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_instant(s, m);
        if (!steady)
            burst_left--;
    endtask

    // even tracks carry one value, odd tracks the other
    task automatic send_split(input sample_t even_v, input sample_t odd_v,
                              input logic [7:0] m);
        track_samples_t s;
        for (int k = 0; k < TRACK_CNT; k++)
            s[k] = (k % 2 == 0) ? even_v : odd_v;
        send_instant(s, m, 1'b0);
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0:       return sample_t'(16'h7fff);
            1:       return sample_t'(16'h8000);
            2:       return sample_t'($urandom_range(0, 20)) - sample_t'(10);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_mask();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h01 << $urandom_range(0, 7);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic vol_t rand_volume();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'hffff;
            2:       return vol_t'($urandom_range(1, 4));
            default: return vol_t'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count, input bit steady);
        track_samples_t s;
        for (int i = 0; i < count; i++)
        begin
            foreach (s[k])
                s[k] = rand_sample();
            send_instant(s, rand_mask(), steady);
        end
        in_valid <= 1'b0;
    endtask

    task automatic send_random_masked(input logic [7:0] m);
        track_samples_t s;
        foreach (s[k])
            s[k] = rand_sample();
        send_instant(s, m, 1'b0);
    endtask

    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        mask_drv   = '0;
        out_ready  = 1'b0;
        rx_hold    = 1'b0;
        rx_cycle   = 0;
        rx_mode    = RX_OPEN;
        burst_left = 0;
        foreach (smp_drv[k])
            smp_drv[k] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset volumes: empty mask, full scale, mixed signs, single tracks
        send_split(16'sh7fff, 16'sh7fff, 8'h00);
        send_split(16'sh7fff, 16'sh7fff, 8'hff);
        send_split(16'sh8000, 16'sh8000, 8'hff);
        send_split(16'sh7fff, 16'sh8000, 8'hff);
        send_split(16'sh8000, 16'sh1234, 8'h01);
        send_split(16'sh1234, 16'sh7fff, 8'h80);
        send_random_masked(8'h55);
        send_random_masked(8'haa);
        in_valid <= 1'b0;
        drain_mixes();

        // volume extremes and small weights where truncation toward zero shows
        write_volume(0, 16'h0000);
        write_volume(1, 16'hffff);
        write_volume(2, 16'h0000);
        write_volume(3, 16'hffff);
        write_volume(4, 16'h0001);
        write_volume(5, 16'h0002);
        write_volume(6, 16'h0003);
        write_volume(7, 16'h8000);
        send_split(16'sh7fff, 16'sh7fff, 8'h05);
        send_split(-16'sd1, 16'sd0, 8'h30);
        send_split(16'sd1, -16'sd2, 8'h30);
        send_split(-16'sd2, 16'sd0, 8'h50);
        send_split(-16'sd7, 16'sd5, 8'h70);
        send_split(16'sh7fff, 16'sh7fff, 8'hff);
        send_split(16'sh8000, 16'sh8000, 8'hff);
        send_split(16'sd0, 16'sh8000, 8'h02);
        send_split(16'sd0, -16'sd12345, 8'h81);
        in_valid <= 1'b0;

        for (int ph = 0; ph < 6; ph++)
        begin
            drain_mixes();
            for (int k = 0; k < TRACK_CNT; k++)
            begin
                case (ph)
                    0:       write_volume(k, 16'hffff);
                    1:       write_volume(k, 16'h0000);
                    default: write_volume(k, rand_volume());
                endcase
            end
            burst_left = 0;
            if (ph == 3)
            begin
                // keep offering beats while the output is held off
                fork
                    hold_receiver(HOLD_LEN);
                    send_random(90, 1'b1);
                join
            end
            else
                send_random(72, 1'b0);
        end

        drain_mixes();
        repeat (TAIL_LEN) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
